@@ hdl/atsb_pkg.sv @@
`default_nettype none

package atsb_pkg;

   localparam int SEQ_W   = 32;
   localparam int LEN_W   = 16;
   localparam int BYTES_W = 24;

   localparam logic [BYTES_W-1:0] MAX_FREE = {BYTES_W{1'b1}};

   // Opcodes of an input item.
   localparam logic [1:0] OP_SEND = 2'd0;
   localparam logic [1:0] OP_DATA = 2'd1;
   localparam logic [1:0] OP_ACK  = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_BUDGET_FULL = 2'd1;
   localparam logic [1:0] STATUS_TABLE_FULL  = 2'd2;

   // May-send event codes.
   localparam logic [1:0] EV_NONE = 2'd0;
   localparam logic [1:0] EV_ON   = 2'd1;
   localparam logic [1:0] EV_OFF  = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_BUFFER_LIMIT   = 1'b0;
   localparam logic CSR_SEND_THRESHOLD = 1'b1;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [LEN_W-1:0] packet_bytes;
      logic [SEQ_W-1:0] peer_seq;
      logic             ack_wanted;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [SEQ_W-1:0]   assigned_seq;
      logic               send_ack;
      logic [SEQ_W-1:0]   ack_seq;
      logic [1:0]         maysend_event;
      logic [BYTES_W-1:0] free_bytes;
   } rsp_type;

   typedef struct packed {
      logic               reg_index;
      logic [BYTES_W-1:0] data;
   } csr_type;

   // Lookup token that walks the row of table cells, one cell per cycle.
   typedef struct packed {
      logic             active;
      logic             is_send;
      logic             done;
      logic [SEQ_W-1:0] seq;
      logic [LEN_W-1:0] len;
   } token_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

@@ hdl/atsb_chan_if.sv @@
`default_nettype none

interface atsb_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hdl/atsb_cell.sv @@
`default_nettype none

module atsb_cell (
   input  logic                clock,
   input  logic                reset,
   input  atsb_pkg::token_type tok_prev,
   output atsb_pkg::token_type tok_next
);
   import atsb_pkg::*;

   logic             valid_ff, valid_in;
   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic [LEN_W-1:0] len_ff, len_in;
   token_type        tok_ff, tok_in;
   logic             claim;
   logic             match;

   always_comb begin
      claim = tok_prev.active && !tok_prev.done && tok_prev.is_send && !valid_ff;
      match = tok_prev.active && !tok_prev.done && !tok_prev.is_send && valid_ff &&
              (seq_ff == tok_prev.seq);

      tok_in   = tok_prev;
      valid_in = valid_ff;
      seq_in   = seq_ff;
      len_in   = len_ff;
      if (claim) begin
         // A send takes the first free entry it passes.
         tok_in.done = 1'b1;
         valid_in    = 1'b1;
         seq_in      = tok_prev.seq;
         len_in      = tok_prev.len;
      end
      if (match) begin
         // An ack frees the first matching entry and carries its length onward.
         tok_in.done = 1'b1;
         tok_in.len  = len_ff;
         valid_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         tok_ff.active <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff <= seq_in;
      len_ff <= len_in;
   end

   assign tok_next = tok_ff;

endmodule

`default_nettype wire

@@ hdl/atsb_ctrl.sv @@
`default_nettype none

module atsb_ctrl (
   input  logic                clock,
   input  logic                reset,
   atsb_chan_if.sink           req_if,
   atsb_chan_if.source         rsp_if,
   atsb_chan_if.sink           csr_if,
   output atsb_pkg::token_type launch_tok,
   input  atsb_pkg::token_type tail_tok
);
   import atsb_pkg::*;

   state_type          state_ff, state_in;
   logic [BYTES_W-1:0] limit_ff;
   logic [BYTES_W-1:0] thresh_ff;
   logic [SEQ_W-1:0]   next_seq_ff, next_seq_in;
   logic [BYTES_W-1:0] used_ff, used_in;
   logic [1:0]         op_ff;
   logic [LEN_W-1:0]   bytes_ff;
   logic [SEQ_W-1:0]   pseq_ff;
   logic               wanted_ff;
   logic               full_ff;
   logic               hit_ff;
   logic [LEN_W-1:0]   hit_len_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;

   req_type            req;
   logic               accept;
   logic [BYTES_W:0]   req_sum;
   logic               budget_full;
   logic               out_free;
   logic               commit;
   logic               send_ok;
   logic               ev_en;
   logic [BYTES_W:0]   held_sum;
   logic [BYTES_W-1:0] hit_len_ext;
   logic [BYTES_W-1:0] free_before;
   logic [BYTES_W-1:0] free_after;

   function automatic logic [BYTES_W-1:0] free_space(input logic [BYTES_W-1:0] limit,
                                                      input logic [BYTES_W-1:0] used);
      logic [BYTES_W-1:0] result;
      if (limit == '0) begin
         result = MAX_FREE;
      end else if (used >= limit) begin
         result = '0;
      end else begin
         result = limit - used;
      end
      return result;
   endfunction

   assign req           = req_if.payload;
   assign req_if.ready  = (state_ff == ST_IDLE);
   assign accept        = req_if.valid && req_if.ready;
   assign csr_if.ready  = 1'b1;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   // Budget check happens at acceptance so a refused send never enters the table.
   always_comb begin
      req_sum     = {1'b0, used_ff} + {{(BYTES_W + 1 - LEN_W){1'b0}}, req.packet_bytes};
      budget_full = (limit_ff != '0) && (req_sum > {1'b0, limit_ff});

      launch_tok.active  = accept && (((req.opcode == OP_SEND) && !budget_full) ||
                                      (req.opcode == OP_ACK));
      launch_tok.is_send = (req.opcode == OP_SEND);
      launch_tok.done    = 1'b0;
      launch_tok.seq     = (req.opcode == OP_SEND) ? next_seq_ff : req.peer_seq;
      launch_tok.len     = req.packet_bytes;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = launch_tok.active ? ST_WALK : ST_FINISH;
            end
         end
         ST_WALK: begin
            if (tail_tok.active) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_free    = !rsp_valid_ff || rsp_if.ready;
      commit      = (state_ff == ST_FINISH) && out_free;
      held_sum    = {1'b0, used_ff} + {{(BYTES_W + 1 - LEN_W){1'b0}}, bytes_ff};
      hit_len_ext = {{(BYTES_W - LEN_W){1'b0}}, hit_len_ff};

      rsp_in      = '0;
      used_in     = used_ff;
      send_ok     = 1'b0;
      ev_en       = 1'b0;
      unique case (op_ff)
         OP_SEND: begin
            if (full_ff) begin
               rsp_in.status = STATUS_BUDGET_FULL;
            end else if (!hit_ff) begin
               rsp_in.status = STATUS_TABLE_FULL;
            end else begin
               send_ok             = 1'b1;
               ev_en               = 1'b1;
               rsp_in.assigned_seq = next_seq_ff;
               used_in             = held_sum[BYTES_W-1:0];
            end
         end
         OP_DATA: begin
            if (wanted_ff) begin
               rsp_in.send_ack = 1'b1;
               rsp_in.ack_seq  = pseq_ff;
            end
         end
         OP_ACK: begin
            if (hit_ff) begin
               ev_en   = 1'b1;
               used_in = (used_ff >= hit_len_ext) ? (used_ff - hit_len_ext) : '0;
            end
         end
         default: begin
         end
      endcase

      free_before = free_space(limit_ff, used_ff);
      free_after  = free_space(limit_ff, used_in);
      rsp_in.free_bytes = free_after;
      if (ev_en && (limit_ff != '0) && (thresh_ff != '0)) begin
         if ((free_before >= thresh_ff) && (free_after < thresh_ff)) begin
            rsp_in.maysend_event = EV_OFF;
         end else if ((free_before < thresh_ff) && (free_after >= thresh_ff)) begin
            rsp_in.maysend_event = EV_ON;
         end
      end

      next_seq_in = send_ok ? (next_seq_ff + 1'b1) : next_seq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= '0;
         thresh_ff    <= '0;
         next_seq_ff  <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_if.valid && csr_if.ready) begin
            if (csr_if.payload.reg_index == CSR_BUFFER_LIMIT) begin
               limit_ff <= csr_if.payload.data;
            end else begin
               thresh_ff <= csr_if.payload.data;
            end
         end
         if (commit) begin
            next_seq_ff  <= next_seq_in;
            used_ff      <= used_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req.opcode;
         bytes_ff  <= req.packet_bytes;
         pseq_ff   <= req.peer_seq;
         wanted_ff <= req.ack_wanted;
         full_ff   <= budget_full;
         hit_ff    <= 1'b0;
      end else if ((state_ff == ST_WALK) && tail_tok.active) begin
         hit_ff     <= tail_tok.done;
         hit_len_ff <= tail_tok.len;
      end
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef ASSERT_OFF
   a_tail_only_in_walk: assert property (@(posedge clock) disable iff (reset)
      tail_tok.active |-> (state_ff == ST_WALK))
      else $error("lookup token left the table outside of a walk");

   a_used_only_on_commit: assert property (@(posedge clock) disable iff (reset)
      !commit |=> $stable(used_ff))
      else $error("byte usage changed without a committed item");

   a_seq_advance: assert property (@(posedge clock) disable iff (reset)
      (commit && (op_ff == OP_SEND) && !full_ff && hit_ff) |=>
      (next_seq_ff == ($past(next_seq_ff) + 32'd1)))
      else $error("sequence number did not advance after an accepted send");

   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && launch_tok.active) |=> (state_ff == ST_WALK))
      else $error("table lookup launched without entering the walk");
`endif

endmodule

`default_nettype wire

@@ hdl/ack_tracked_send_buffer.sv @@
// A send with budget room or an ack walks a lookup token through the row of table cells,
// one cell per cycle, before its result is registered; data, unused opcodes and
// over-budget sends go straight to the result. A new item is taken only once the last
// one has been committed, and the commit waits until the output register is free.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active high) clears all entry valid bits, counters, settings and control state.
`default_nettype none

module ack_tracked_send_buffer #(
   parameter int TABLE_DEPTH = 16
) (
   input logic         clock,
   input logic         reset,
   atsb_chan_if.sink   req_if,
   atsb_chan_if.source rsp_if,
   atsb_chan_if.sink   csr_if
);
   import atsb_pkg::*;

   token_type chain [TABLE_DEPTH+1];

   atsb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .rsp_if     (rsp_if),
      .csr_if     (csr_if),
      .launch_tok (chain[0]),
      .tail_tok   (chain[TABLE_DEPTH])
   );

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      atsb_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .tok_prev (chain[i]),
         .tok_next (chain[i+1])
      );
   end

endmodule

`default_nettype wire

@@ sim/ack_tracked_send_buffer_tb.sv @@
module ack_tracked_send_buffer_tb;
   import atsb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 16;
   localparam int NUM_PHASES  = 9;
   localparam int PHASE_ITEMS = 72;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_WAIT  = 4 * TABLE_DEPTH;
   localparam int CYCLE_LIMIT = 600000;

   // The package names no code for the fourth opcode value.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef enum logic {ROW_ITEM, ROW_SETTING} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      req_type            item;
      logic [BYTES_W-1:0] limit;
      logic [BYTES_W-1:0] threshold;
      logic               pinned;
      rsp_type            want;
   } row_type;

   typedef struct packed {
      logic [BYTES_W-1:0] limit;
      logic [BYTES_W-1:0] threshold;
      logic [7:0]         send_pct;
   } phase_type;

   logic clock;
   logic reset;

   atsb_chan_if #(.payload_type(req_type)) req_ch ();
   atsb_chan_if #(.payload_type(rsp_type)) rsp_ch ();
   atsb_chan_if #(.payload_type(csr_type)) csr_ch ();

   ack_tracked_send_buffer #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch),
      .csr_if(csr_ch)
   );

   // Shadow copy of the buffer state and registers.
   logic [BYTES_W-1:0] cfg_limit;
   logic [BYTES_W-1:0] cfg_threshold;
   logic [SEQ_W-1:0]   seq_counter;
   logic [BYTES_W-1:0] bytes_in_flight;
   logic               slot_valid [TABLE_DEPTH];
   logic [SEQ_W-1:0]   slot_seq [TABLE_DEPTH];
   logic [LEN_W-1:0]   slot_len [TABLE_DEPTH];

   rsp_type   awaited_rsp [$];
   row_type   plan [$];
   phase_type phase_list [NUM_PHASES];

   int      mismatch_cnt = 0;
   int      req_idle_pct = 0;
   int      rsp_idle_pct = 0;
   int      hold_left = 0;
   bit      hold_req = 1'b0;
   rsp_type mon_got;
   rsp_type mon_want;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[ack_tracked_send_buffer] ERROR");
      $finish;
   end

   function automatic logic [BYTES_W-1:0] free_space();
      if (cfg_limit == '0) return MAX_FREE;
      if (bytes_in_flight >= cfg_limit) return '0;
      return cfg_limit - bytes_in_flight;
   endfunction

   function automatic logic [1:0] threshold_crossing(logic [BYTES_W-1:0] was_free,
                                                     logic [BYTES_W-1:0] now_free);
      if (cfg_limit == '0 || cfg_threshold == '0) return EV_NONE;
      if (was_free >= cfg_threshold && now_free < cfg_threshold) return EV_OFF;
      if (was_free < cfg_threshold && now_free >= cfg_threshold) return EV_ON;
      return EV_NONE;
   endfunction

   // Advances the shadow state by one item and returns the answer it must produce.
   function automatic rsp_type buffer_step(req_type item);
      rsp_type            res;
      logic [BYTES_W-1:0] was_free;
      int                 slot;
      bit                 hit;
      res = '0;
      was_free = free_space();
      case (item.opcode)
         OP_SEND: begin
            slot = -1;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (!slot_valid[i] && slot < 0) slot = i;
            end
            if (cfg_limit != '0 &&
                ({1'b0, bytes_in_flight} + item.packet_bytes) > {1'b0, cfg_limit}) begin
               res.status = STATUS_BUDGET_FULL;
            end else if (slot < 0) begin
               res.status = STATUS_TABLE_FULL;
            end else begin
               slot_valid[slot] = 1'b1;
               slot_seq[slot] = seq_counter;
               slot_len[slot] = item.packet_bytes;
               res.assigned_seq = seq_counter;
               seq_counter = seq_counter + 1'b1;
               bytes_in_flight = bytes_in_flight + item.packet_bytes;
               res.maysend_event = threshold_crossing(was_free, free_space());
            end
         end
         OP_DATA: begin
            if (item.ack_wanted) begin
               res.send_ack = 1'b1;
               res.ack_seq = item.peer_seq;
            end
         end
         OP_ACK: begin
            hit = 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (!hit && slot_valid[i] && slot_seq[i] == item.peer_seq) begin
                  hit = 1'b1;
                  slot_valid[i] = 1'b0;
                  bytes_in_flight = (bytes_in_flight >= slot_len[i]) ?
                                    bytes_in_flight - slot_len[i] : '0;
                  res.maysend_event = threshold_crossing(was_free, free_space());
               end
            end
         end
         default: ;
      endcase
      res.free_bytes = free_space();
      return res;
   endfunction

   // Random item shaped by the current table contents, so most acks hit a live entry.
   function automatic req_type pick_item(int send_pct);
      req_type item;
      int      roll;
      int      span;
      int      start;
      bit      found;
      item.opcode = OP_UNUSED;
      item.packet_bytes = LEN_W'($urandom_range(0, 16'hFFFF));
      item.peer_seq = $urandom();
      item.ack_wanted = 1'($urandom_range(1));
      roll = $urandom_range(99);
      if (roll < send_pct) begin
         item.opcode = OP_SEND;
         if (cfg_limit != '0 && $urandom_range(9) != 0) begin
            span = cfg_limit / 3 + 1;
            if (span > 16'hFFFF) span = 16'hFFFF;
            item.packet_bytes = LEN_W'($urandom_range(0, span));
         end
      end else if (roll < send_pct + 15) begin
         item.opcode = OP_DATA;
      end else if (roll < 97) begin
         item.opcode = OP_ACK;
         found = 1'b0;
         if ($urandom_range(4) != 0) begin
            start = $urandom_range(TABLE_DEPTH - 1);
            for (int n = 0; n < TABLE_DEPTH; n++) begin
               if (!found && slot_valid[(start + n) % TABLE_DEPTH]) begin
                  found = 1'b1;
                  item.peer_seq = slot_seq[(start + n) % TABLE_DEPTH];
               end
            end
         end
         // An ack for the next number is one that no entry can hold yet.
         if (!found && $urandom_range(1)) item.peer_seq = seq_counter;
      end
      return item;
   endfunction

   function automatic void plan_item(logic [1:0] op, logic [LEN_W-1:0] bytes,
                                     logic [SEQ_W-1:0] seq, logic wanted);
      row_type row;
      row = '0;
      row.kind = ROW_ITEM;
      row.item = '{opcode: op, packet_bytes: bytes, peer_seq: seq, ack_wanted: wanted};
      plan = {plan, row};
   endfunction

   function automatic void plan_pinned(logic [1:0] op, logic [LEN_W-1:0] bytes,
                                       logic [SEQ_W-1:0] seq, logic wanted, rsp_type want);
      plan_item(op, bytes, seq, wanted);
      plan[plan.size() - 1].pinned = 1'b1;
      plan[plan.size() - 1].want = want;
   endfunction

   function automatic void plan_setting(logic [BYTES_W-1:0] limit,
                                        logic [BYTES_W-1:0] threshold);
      row_type row;
      row = '0;
      row.kind = ROW_SETTING;
      row.limit = limit;
      row.threshold = threshold;
      plan = {plan, row};
   endfunction

   // Valid stays high after a transfer so that back-to-back items never toggle it
   // within one step; it is lowered only on an idle cycle or a pause.
   task automatic push_req(input req_type item, input logic pinned, input rsp_type pin_rsp);
      rsp_type want;
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= item;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      want = buffer_step(item);
      if (pinned) want = pin_rsp;
      awaited_rsp = {awaited_rsp, want};
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      wait (awaited_rsp.size() == 0);
   endtask

   task automatic set_buffer_regs(input logic [BYTES_W-1:0] limit,
                                  input logic [BYTES_W-1:0] threshold);
      drain_results();
      csr_ch.valid   <= 1'b1;
      csr_ch.payload <= '{reg_index: CSR_BUFFER_LIMIT, data: limit};
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      cfg_limit = limit;
      csr_ch.payload <= '{reg_index: CSR_SEND_THRESHOLD, data: threshold};
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      cfg_threshold = threshold;
      csr_ch.valid <= 1'b0;
   endtask

   task automatic flag_mismatch(input string what);
      if (mismatch_cnt < 10) $display("%0t ns: %s", $realtime, what);
      mismatch_cnt++;
   endtask

   // Receiver: random ready, with an occasional long hold-off requested by the stimulus.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (hold_req) begin
         hold_req = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         mon_got = rsp_ch.payload;
         if (awaited_rsp.size() == 0) begin
            flag_mismatch($sformatf("result with nothing awaited: status=%0d free=%h",
                                    mon_got.status, mon_got.free_bytes));
         end else begin
            mon_want = awaited_rsp.pop_front();
            if (mon_got.status !== mon_want.status ||
                mon_got.assigned_seq !== mon_want.assigned_seq ||
                mon_got.send_ack !== mon_want.send_ack ||
                mon_got.ack_seq !== mon_want.ack_seq ||
                mon_got.maysend_event !== mon_want.maysend_event ||
                mon_got.free_bytes !== mon_want.free_bytes) begin
               flag_mismatch({
                  $sformatf("expected status=%0d aseq=%h ack=%0d kseq=%h ev=%0d free=%h",
                            mon_want.status, mon_want.assigned_seq, mon_want.send_ack,
                            mon_want.ack_seq, mon_want.maysend_event,
                            mon_want.free_bytes),
                  $sformatf(", got status=%0d aseq=%h ack=%0d kseq=%h ev=%0d free=%h",
                            mon_got.status, mon_got.assigned_seq, mon_got.send_ack,
                            mon_got.ack_seq, mon_got.maysend_event,
                            mon_got.free_bytes)});
            end
         end
      end
   end

   initial begin
      logic [BYTES_W-1:0] lim_next;
      logic [BYTES_W-1:0] thr_next;

      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      csr_ch.valid   = 1'b0;
      csr_ch.payload = '0;
      cfg_limit       = '0;
      cfg_threshold   = '0;
      seq_counter     = '0;
      bytes_in_flight = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         slot_valid[i] = 1'b0;
         slot_seq[i] = '0;
         slot_len[i] = '0;
      end

      // Unlimited budget straight after reset: free space reads as saturated.
      plan_pinned(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                  '{STATUS_OK, 32'd0, 1'b0, 32'd0, EV_NONE, MAX_FREE});
      plan_pinned(OP_DATA, 16'h0000, 32'hFFFF_FFFF, 1'b1,
                  '{STATUS_OK, 32'd0, 1'b1, 32'hFFFF_FFFF, EV_NONE, MAX_FREE});
      plan_pinned(OP_DATA, 16'hFFFF, 32'h0000_0000, 1'b0,
                  '{STATUS_OK, 32'd0, 1'b0, 32'd0, EV_NONE, MAX_FREE});
      plan_pinned(OP_ACK, 16'h0000, 32'hFFFF_FFFF, 1'b0,
                  '{STATUS_OK, 32'd0, 1'b0, 32'd0, EV_NONE, MAX_FREE});
      plan_pinned(OP_SEND, 16'hFFFF, 32'd0, 1'b0,
                  '{STATUS_OK, 32'd0, 1'b0, 32'd0, EV_NONE, MAX_FREE});
      plan_pinned(OP_SEND, 16'h0000, 32'd0, 1'b0,
                  '{STATUS_OK, 32'd1, 1'b0, 32'd0, EV_NONE, MAX_FREE});
      plan_pinned(OP_ACK, 16'h0000, 32'd0, 1'b0,
                  '{STATUS_OK, 32'd0, 1'b0, 32'd0, EV_NONE, MAX_FREE});
      plan_item(OP_ACK, 16'h0000, 32'd1, 1'b0);
      // Small budget: cross the threshold down, hit the budget, fill it exactly.
      plan_setting(24'd100, 24'd40);
      plan_item(OP_SEND, 16'd61, 32'd0, 1'b0);
      plan_pinned(OP_SEND, 16'd40, 32'd0, 1'b0,
                  '{STATUS_BUDGET_FULL, 32'd0, 1'b0, 32'd0, EV_NONE, 24'd39});
      plan_item(OP_SEND, 16'd39, 32'd0, 1'b0);
      plan_item(OP_SEND, 16'd0, 32'd0, 1'b0);
      plan_item(OP_ACK, 16'd0, 32'd2, 1'b1);
      plan_item(OP_DATA, 16'h1234, 32'hA5A5_5A5A, 1'b1);
      // Limit dropped below the bytes still in flight.
      plan_setting(24'd20, 24'd40);
      plan_pinned(OP_SEND, 16'd0, 32'd0, 1'b0,
                  '{STATUS_BUDGET_FULL, 32'd0, 1'b0, 32'd0, EV_NONE, 24'd0});
      plan_item(OP_ACK, 16'd0, 32'd3, 1'b0);
      plan_item(OP_ACK, 16'd0, 32'd4, 1'b0);
      plan_setting(MAX_FREE, MAX_FREE);
      plan_item(OP_SEND, 16'd1, 32'd0, 1'b0);
      plan_item(OP_ACK, 16'd0, 32'd5, 1'b0);

      // The first phase sends heavily with no budget so that the table fills up.
      phase_list[0] = '{24'd0, 24'd0, 8'd70};
      phase_list[1] = '{24'd0, 24'd1000, 8'd45};
      phase_list[2] = '{24'd1000, 24'd400, 8'd45};
      phase_list[3] = '{24'd300, 24'd0, 8'd45};
      phase_list[4] = '{MAX_FREE, MAX_FREE, 8'd55};
      phase_list[5] = '{24'd65535, 24'd30000, 8'd45};
      phase_list[6] = '{24'd1, 24'd1, 8'd45};
      phase_list[7] = '{24'd0, 24'd0, 8'd45};
      phase_list[8] = '{24'd5000, 24'd2500, 8'd50};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 17;
      rsp_idle_pct = 68;
      foreach (plan[r]) begin
         if (plan[r].kind == ROW_SETTING) begin
            set_buffer_regs(plan[r].limit, plan[r].threshold);
         end else begin
            push_req(plan[r].item, plan[r].pinned, plan[r].want);
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         lim_next = phase_list[p].limit;
         thr_next = phase_list[p].threshold;
         // The zero limit and threshold of phase 7 stand for a randomly drawn setting.
         if (p == 7) begin
            lim_next = BYTES_W'($urandom_range(1, MAX_FREE));
            thr_next = BYTES_W'($urandom_range(1, lim_next));
         end
         set_buffer_regs(lim_next, thr_next);
         req_idle_pct = (p < 3) ? 17 : (p < 6) ? 68 : 0;
         rsp_idle_pct = (p < 3) ? 68 : (p < 6) ? 17 : 0;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 1 && k == 20) hold_req = 1'b1;
            if (p == 4 && k == 40) drain_results();
            push_req(pick_item(phase_list[p].send_pct), 1'b0, '0);
         end
      end

      drain_results();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_cnt == 0 && awaited_rsp.size() == 0) begin
         $display("[ack_tracked_send_buffer] OK");
      end else begin
         $display("[ack_tracked_send_buffer] ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/atsb_pkg.sv
hdl/atsb_chan_if.sv
hdl/atsb_cell.sv
hdl/atsb_ctrl.sv
hdl/ack_tracked_send_buffer.sv
sim/ack_tracked_send_buffer_tb.sv
